FILE: design/vr2d_pkg.sv
// Package for the 2D vector rotator: widths, constants, angle table and output rounding.
`timescale 1ns / 1ps

package vr2d_pkg;

    // Default number of micro-rotation stages and the size of the angle table
    localparam int STAGES_DEF = 16;
    localparam int TABLE_LEN  = 24;

    // Field widths
    localparam int IN_W    = 18;
    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 19;

    // Datapath: 8 fraction bits, headroom for negation and CORDIC growth
    localparam int FRAC_BITS = 8;
    localparam int DW        = 30;
    // Residual angle in turn units (2^32 per turn) plus a sign bit of headroom
    localparam int ZW        = 33;

    // Inverse CORDIC gain, 20 fraction bits, held as a positive signed value
    localparam int GAIN_BITS = 20;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam logic signed [GAIN_W-1:0] INV_GAIN = 21'sd636751;
    localparam int PW        = DW + GAIN_W;
    localparam int RND_SHIFT = FRAC_BITS + GAIN_BITS;

    localparam logic signed [ZW-1:0] HALF_TURN    = 33'sh0_8000_0000;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sh0_4000_0000;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

    typedef logic signed [DW-1:0]    coord_t;
    typedef logic signed [ZW-1:0]    angle_t;
    typedef logic signed [PW-1:0]    prod_t;
    typedef logic signed [OUT_W-1:0] result_t;

    // atan(2^-i) in turn units, rounded to nearest
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

    // Round half up to an integer, then saturate to the output range
    function automatic result_t round_sat(input prod_t prod);
        prod_t                         sum;
        logic signed [PW-RND_SHIFT-1:0] whole;
        result_t                       res;
        sum   = prod + (prod_t'(1) <<< (RND_SHIFT - 1));
        whole = sum[PW-1:RND_SHIFT];
        if (whole > (PW - RND_SHIFT)'(OUT_MAX))
            res = OUT_MAX;
        else if (whole < (PW - RND_SHIFT)'(OUT_MIN))
            res = OUT_MIN;
        else
            res = whole[OUT_W-1:0];
        return res;
    endfunction

endpackage

FILE: design/vector_rotate_2d.sv
// Pipelined CORDIC rotator: turns a 2D vector by a binary angle, one item per cycle.
//
//  channel | ports                           | handshake
//  --------+---------------------------------+-----------------------------------
//  input   | vec_x, vec_y, turn_angle        | taken when start high, busy low
//  result  | rot_x, rot_y                    | done high for one cycle, no stall
//
//  An item enters every cycle; busy stays low. The stages are, in order:
//  one fold stage, one stage per micro-rotation, a gain multiply and a
//  round/saturate stage. The gain multiplier (30 x 21 bits) sets the clock.
//  rst_n clears the valid bits only; data registers carry no reset.
//  The receiver cannot stall, so nothing is ever held back.
`timescale 1ns / 1ps

module vector_rotate_2d #(
    parameter int ROT_STAGES = vr2d_pkg::STAGES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [vr2d_pkg::IN_W-1:0]       vec_x,
    input  logic signed [vr2d_pkg::IN_W-1:0]       vec_y,
    input  logic signed [vr2d_pkg::ANGLE_W-1:0]    turn_angle,
    output logic                                   done,
    output logic signed [vr2d_pkg::OUT_W-1:0]      rot_x,
    output logic signed [vr2d_pkg::OUT_W-1:0]      rot_y
);
    import vr2d_pkg::*;

    localparam int NSTG = (ROT_STAGES > TABLE_LEN) ? TABLE_LEN : ROT_STAGES;
    localparam int LAT  = NSTG + 3;

    // Valid bits: fold stage, one per micro-rotation, multiply; done_reg marks the output
    logic   [NSTG+1:0] v_reg;
    coord_t            x_reg [0:NSTG];
    coord_t            y_reg [0:NSTG];
    angle_t            z_reg [0:NSTG];
    prod_t             px_reg, py_reg;
    result_t           rot_x_reg, rot_y_reg;
    logic              done_reg;

    logic   accept;
    coord_t x0_next, y0_next;
    angle_t z0_next;
    coord_t x_ext, y_ext;
    angle_t z_ext;
    prod_t  px_next, py_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Fold: beyond a quarter turn, negate the vector and remove a half turn
    always_comb
    begin
        x_ext = {{(DW-IN_W-FRAC_BITS){vec_x[IN_W-1]}}, vec_x, {FRAC_BITS{1'b0}}};
        y_ext = {{(DW-IN_W-FRAC_BITS){vec_y[IN_W-1]}}, vec_y, {FRAC_BITS{1'b0}}};
        z_ext = {turn_angle[ANGLE_W-1], turn_angle, {(ZW-ANGLE_W-1){1'b0}}};
        if (turn_angle[ANGLE_W-1] != turn_angle[ANGLE_W-2])
        begin
            x0_next = -x_ext;
            y0_next = -y_ext;
            z0_next = turn_angle[ANGLE_W-1] ? (z_ext + HALF_TURN) : (z_ext - HALF_TURN);
        end
        else
        begin
            x0_next = x_ext;
            y0_next = y_ext;
            z0_next = z_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x0_next;
        y_reg[0] <= y0_next;
        z_reg[0] <= z0_next;
    end

    // Micro-rotation stages, one per table entry in use (NSTG of them)
    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        localparam angle_t ATAN = angle_t'({1'b0, atan_turn(i)});
        coord_t x_next, y_next;
        angle_t z_next;

        always_comb
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - ATAN;
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            z_reg[i+1] <= z_next;
        end
    end

    // Gain compensation
    assign px_next = prod_t'(x_reg[NSTG]) * prod_t'(INV_GAIN);
    assign py_next = prod_t'(y_reg[NSTG]) * prod_t'(INV_GAIN);

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        rot_x_reg <= round_sat(px_reg);
        rot_y_reg <= round_sat(py_reg);
    end

    // Valid bits travel with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[NSTG:0], accept};
            done_reg <= v_reg[NSTG+1];
        end
    end

    assign done  = done_reg;
    assign rot_x = rot_x_reg;
    assign rot_y = rot_y_reg;

    // Every accepted item comes out after the full latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted item did not complete after pipeline latency");

    // No result without an item accepted the latency earlier
    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted item");

    // Folded angle lies within a quarter turn either way
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> (z_reg[0] >= -QUARTER_TURN && z_reg[0] < QUARTER_TURN))
        else $error("folded angle outside the convergence range");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the pipelined CORDIC vector rotator.
`timescale 1ns / 1ps

module tb;

    import vr2d_pkg::*;

    localparam int  STAGE_CNT  = 16;
    localparam int  STAGES_RUN = (STAGE_CNT > 24) ? 24 : STAGE_CNT;
    localparam int  DRAIN_CYC  = STAGE_CNT + 12;
    localparam int  CYCLE_CAP  = 200000;
    localparam int  IDLE_PCT   = 25;

    localparam longint Q_TURN   = 64'sd1073741824;
    localparam longint H_TURN   = 64'sd2147483648;
    localparam longint GAIN_INV = 64'sd636751;
    localparam int     ROUND_SH = 28;
    localparam longint SAT_HI   = 64'sd262143;
    localparam longint SAT_LO   = -64'sd262144;

    typedef struct {
        logic signed [IN_W-1:0]    in_x;
        logic signed [IN_W-1:0]    in_y;
        logic signed [ANGLE_W-1:0] in_ang;
        result_t                   out_x;
        result_t                   out_y;
    } rotation_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [IN_W-1:0]    vec_x;
    logic signed [IN_W-1:0]    vec_y;
    logic signed [ANGLE_W-1:0] turn_angle;
    logic                      done;
    logic signed [OUT_W-1:0]   rot_x;
    logic signed [OUT_W-1:0]   rot_y;

    rotation_t pending_rotations[$];
    int        mismatch_cnt;
    int        cycle_cnt;

    // atan(2^-k) in turn units (2^32 per turn)
    longint arctan_turns [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    vector_rotate_2d #(
        .ROT_STAGES (STAGE_CNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .turn_angle (turn_angle),
        .done       (done),
        .rot_x      (rot_x),
        .rot_y      (rot_y)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Remove the CORDIC gain, round half up, clip to the output range
    function automatic result_t gain_round_clip(input longint acc);
        longint prod;
        longint whole;
        prod  = acc * GAIN_INV;
        whole = (prod + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (whole > SAT_HI)
            whole = SAT_HI;
        if (whole < SAT_LO)
            whole = SAT_LO;
        return result_t'(whole);
    endfunction

    // Expected rotation of one vector
    function automatic rotation_t rotate_vector(input logic signed [IN_W-1:0] vx,
                                                input logic signed [IN_W-1:0] vy,
                                                input logic signed [ANGLE_W-1:0] ang);
        rotation_t rot;
        longint    cx;
        longint    cy;
        longint    resid;
        longint    step_x;
        longint    step_y;
        int        k;
        cx    = longint'(vx) * 256;
        cy    = longint'(vy) * 256;
        resid = longint'(ang) * 65536;
        // fold into the right half plane: negate and drop a half turn
        if (resid >= Q_TURN || resid < -Q_TURN)
        begin
            cx = -cx;
            cy = -cy;
            if (resid > 0)
                resid = resid - H_TURN;
            else
                resid = resid + H_TURN;
        end
        for (k = 0; k < STAGES_RUN; k++)
        begin
            step_x = cy >>> k;
            step_y = cx >>> k;
            if (resid >= 0)
            begin
                cx    = cx - step_x;
                cy    = cy + step_y;
                resid = resid - arctan_turns[k];
            end
            else
            begin
                cx    = cx + step_x;
                cy    = cy - step_y;
                resid = resid + arctan_turns[k];
            end
        end
        rot.in_x   = vx;
        rot.in_y   = vy;
        rot.in_ang = ang;
        rot.out_x  = gain_round_clip(cx);
        rot.out_y  = gain_round_clip(cy);
        return rot;
    endfunction

    // Result check first, then record any item taken at this edge
    always @(posedge clk)
    begin
        rotation_t want;
        if (rst_n && done)
        begin
            if (pending_rotations.size() == 0)
            begin
                $error("unexpected result rot_x=%0d rot_y=%0d", rot_x, rot_y);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_rotations.pop_front();
                if (rot_x !== want.out_x)
                begin
                    $error("rot_x expected %0d actual %0d (x=%0d y=%0d angle=%0d)",
                           want.out_x, rot_x, want.in_x, want.in_y, want.in_ang);
                    mismatch_cnt++;
                end
                if (rot_y !== want.out_y)
                begin
                    $error("rot_y expected %0d actual %0d (x=%0d y=%0d angle=%0d)",
                           want.out_y, rot_y, want.in_x, want.in_y, want.in_ang);
                    mismatch_cnt++;
                end
            end
        end
        if (rst_n && start && !busy)
            pending_rotations.push_back(rotate_vector(vec_x, vec_y, turn_angle));
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("vector_rotate_2d verification failed");
            $finish;
        end
    end

    // Present one item and hold it until taken; optional idle cycles in front
    task automatic send_vector(input logic signed [IN_W-1:0] vx,
                               input logic signed [IN_W-1:0] vy,
                               input logic signed [ANGLE_W-1:0] ang,
                               input bit with_gaps);
        while (with_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        vec_x      <= vx;
        vec_y      <= vy;
        turn_angle <= ang;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Coordinate biased towards the edges of its range and towards zero
    function automatic logic signed [IN_W-1:0] pick_coord();
        case ($urandom_range(19))
            0:       return {1'b0, {(IN_W-1){1'b1}}};
            1:       return {1'b1, {(IN_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            4:       return IN_W'($urandom_range(15)) - IN_W'(8);
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Angle biased towards the fold boundaries, the half-turn wrap and zero
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(19))
            0:       return 16'sh4000 + ANGLE_W'($urandom_range(2)) - 16'sd1;
            1:       return 16'shC000 + ANGLE_W'($urandom_range(2)) - 16'sd1;
            2:       return 16'sh8000;
            3:       return 16'sh7FFF;
            4:       return ANGLE_W'($urandom_range(2)) - 16'sd1;
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    // Field extremes and the zero vector
    task automatic test_extremes();
        send_vector(18'sh1FFFF, 18'sh1FFFF, 16'sd0, 1'b0);
        send_vector(18'sh20000, 18'sh20000, 16'sd0, 1'b0);
        send_vector(18'sh1FFFF, 18'sh20000, 16'sh7FFF, 1'b0);
        send_vector(18'sh20000, 18'sh1FFFF, 16'sh8000, 1'b0);
        send_vector(18'sd0, 18'sd0, 16'sd12345, 1'b0);
        send_vector(18'sh1FFFF, 18'sh1FFFF, 16'sd8192, 1'b0);
        send_vector(18'sh20000, 18'sh20000, 16'sd8192, 1'b0);
        send_vector(18'sh20000, 18'sh1FFFF, -16'sd8192, 1'b0);
        send_vector(-18'sd1, 18'sd1, 16'sd1, 1'b0);
    endtask

    // Quarter and half turn folding, including exactly minus pi
    task automatic test_angle_folding();
        send_vector(18'sd1000, 18'sd500, 16'sd16383, 1'b0);
        send_vector(18'sd1000, 18'sd500, 16'sd16384, 1'b0);
        send_vector(18'sd1000, 18'sd500, 16'sd16385, 1'b0);
        send_vector(18'sd1000, 18'sd500, -16'sd16384, 1'b0);
        send_vector(18'sd1000, 18'sd500, -16'sd16385, 1'b0);
        send_vector(18'sd1000, 18'sd500, 16'sh8000, 1'b0);
        send_vector(-18'sd77777, 18'sd4321, 16'sh8001, 1'b0);
        send_vector(18'sd65536, -18'sd3, 16'sd24576, 1'b0);
        send_vector(18'sd65536, -18'sd3, -16'sd24576, 1'b0);
        send_vector(18'sd100, 18'sd0, -16'sd1, 1'b0);
    endtask

    // Random items with idle cycles between them
    task automatic test_random_with_gaps(input int count);
        for (int n = 0; n < count; n++)
            send_vector(pick_coord(), pick_coord(), pick_angle(), 1'b1);
    endtask

    // Random items back to back at full rate
    task automatic test_random_back_to_back(input int count);
        for (int n = 0; n < count; n++)
            send_vector(pick_coord(), pick_coord(), pick_angle(), 1'b0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        vec_x        = '0;
        vec_y        = '0;
        turn_angle   = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_angle_folding();
        test_random_with_gaps(600);
        test_random_back_to_back(400);
        test_random_with_gaps(400);

        // drain the pipeline, then allow time for any stray result
        start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("vector_rotate_2d verification clean");
        else
            $display("vector_rotate_2d verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/vr2d_pkg.sv
design/vector_rotate_2d.sv
test/tb.sv
